### rtl/atbe_pkg.sv
// ----------------------------------------------------------------------------
// atbe_pkg
// Shared types, constants and helpers of the attack tracker engine.
// ----------------------------------------------------------------------------
package atbe_pkg;

  localparam int unsigned PendDepthDef = 16;
  localparam int unsigned BlkDepthDef  = 16;
  localparam int unsigned OffDepthDef  = 64;
  localparam int unsigned TimeBitsDef  = 32;

  localparam logic [2:0] CfgAbuseThr   = 3'd0;
  localparam logic [2:0] CfgBlacklThr  = 3'd1;
  localparam logic [2:0] CfgPardonBase = 3'd2;
  localparam logic [2:0] CfgStaleLimit = 3'd3;
  localparam logic [2:0] CfgBlacklEn   = 3'd4;

  localparam logic [2:0] StAlready   = 3'd0;
  localparam logic [2:0] StWhite     = 3'd1;
  localparam logic [2:0] StCounted   = 3'd2;
  localparam logic [2:0] StBlocked   = 3'd3;
  localparam logic [2:0] StPerm      = 3'd4;
  localparam logic [2:0] StFull      = 3'd5;
  localparam logic [2:0] StReleased  = 3'd6;
  localparam logic [2:0] StNone      = 3'd7;

  localparam logic OpReport = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        addr_kind;
    logic [9:0]  service;
    logic [9:0]  danger;
    logic        whitelisted;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] res_addr_hi;
    logic [63:0] res_addr_lo;
    logic        res_kind;
    logic [9:0]  res_service;
    logic [31:0] block_seconds;
    logic [31:0] offender_danger;
    logic [15:0] offender_abuses;
    logic        to_blacklist;
    logic        last;
  } out_item_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/atbe_ram.sv
// ----------------------------------------------------------------------------
// atbe_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// ----------------------------------------------------------------------------
module atbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/attack_tracker_block_engine_top.sv
// ----------------------------------------------------------------------------
// attack_tracker_block_engine_top
// Per-source attack tracker: pending, blocked and offender tables in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (valid/ready) carry either an attack report or a time tick.
//   A report gives exactly one result item; a tick gives one result per
//   released block, or one "none" result, the final one flagged last.
//   Tables are read one entry per cycle, except while a tick sweep pauses
//   for a stalled output, through RAMs with registered read data.
//   A report that reaches a block purges the pending table, searches the
//   blocked, pending and offender tables, updates the entries and then
//   takes its escalation steps; already blocked, whitelisted, counted and
//   table-full answers leave sooner.
//   A tick sweeps the blocked table once and pauses while a release waits
//   for the output register.
//   Reset clears all valid bits and loads the register defaults; table
//   contents need no clearing. When the receiver stalls, the held result
//   waits in the output register and the sweep pauses.
//   The next item is taken once the previous one has fully finished.
//   Configuration writes are taken on any cycle with cfg_we_i high and
//   belong between items.
// ----------------------------------------------------------------------------
module attack_tracker_block_engine_top #(
  parameter int unsigned PEND_DEPTH = atbe_pkg::PendDepthDef,
  parameter int unsigned BLK_DEPTH  = atbe_pkg::BlkDepthDef,
  parameter int unsigned OFF_DEPTH  = atbe_pkg::OffDepthDef,
  parameter int unsigned TIME_BITS  = atbe_pkg::TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  atbe_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output atbe_pkg::out_item_t out_item_o
);

  localparam int unsigned PW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
  localparam int unsigned BW = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int unsigned OW = (OFF_DEPTH > 1) ? $clog2(OFF_DEPTH) : 1;
  localparam int unsigned TB = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int unsigned PWW = 64 + 64 + 11 + TB + TB + 16 + 32;
  localparam int unsigned BWW = 64 + 64 + 11 + TB + 32;
  localparam int unsigned OWW = 64 + 64 + 1 + 16 + 32 + TB;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PURGE  = 4'd1;
  localparam logic [3:0] S_BSRCH  = 4'd2;
  localparam logic [3:0] S_PSRCH  = 4'd3;
  localparam logic [3:0] S_PUPD   = 4'd4;
  localparam logic [3:0] S_OSRCH  = 4'd5;
  localparam logic [3:0] S_OUPD   = 4'd6;
  localparam logic [3:0] S_ESC    = 4'd7;
  localparam logic [3:0] S_BWR    = 4'd8;
  localparam logic [3:0] S_TICK   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_TOUT   = 4'd11;
  localparam logic [3:0] S_PREAD  = 4'd12;

  // configuration
  logic [31:0] abuse_thr_q, blk_thr_q, pardon_q, stale_q;
  logic        bl_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abuse_thr_q <= 32'd40;
      blk_thr_q   <= 32'd120;
      pardon_q    <= 32'd1200;
      stale_q     <= 32'd1200;
      bl_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        atbe_pkg::CfgAbuseThr:   abuse_thr_q <= cfg_wdata_i;
        atbe_pkg::CfgBlacklThr:  blk_thr_q   <= cfg_wdata_i;
        atbe_pkg::CfgPardonBase: pardon_q    <= cfg_wdata_i;
        atbe_pkg::CfgStaleLimit: stale_q     <= cfg_wdata_i;
        atbe_pkg::CfgBlacklEn:   bl_en_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // memories
  logic           p_we, b_we, o_we;
  logic [PW-1:0]  p_wa, p_ra;
  logic [BW-1:0]  b_wa, b_ra;
  logic [OW-1:0]  o_wa, o_ra;
  logic [PWW-1:0] p_wd, p_rd;
  logic [BWW-1:0] b_wd, b_rd;
  logic [OWW-1:0] o_wd, o_rd;

  atbe_ram #(.Width(PWW), .Depth(PEND_DEPTH)) u_pend (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));
  atbe_ram #(.Width(BWW), .Depth(BLK_DEPTH)) u_blk (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));
  atbe_ram #(.Width(OWW), .Depth(OFF_DEPTH)) u_off (
    .clk_i, .we_i(o_we), .waddr_i(o_wa), .wdata_i(o_wd), .raddr_i(o_ra), .rdata_o(o_rd));

  // unpacked read fields
  logic [63:0] pr_hi, pr_lo, br_hi, br_lo, or_hi, or_lo;
  logic [10:0] pr_ks, br_ks;
  logic [TB-1:0] pr_first, pr_last, br_since, or_last;
  logic [15:0] pr_hits, or_ab;
  logic [31:0] pr_dng, br_dur, or_dng;
  logic        or_kind;
  assign {pr_hi, pr_lo, pr_ks, pr_first, pr_last, pr_hits, pr_dng} = p_rd;
  assign {br_hi, br_lo, br_ks, br_since, br_dur} = b_rd;
  assign {or_hi, or_lo, or_kind, or_ab, or_dng, or_last} = o_rd;

  logic [PEND_DEPTH-1:0] pv_q, pv_d;
  logic [BLK_DEPTH-1:0]  bv_q, bv_d;
  logic [OFF_DEPTH-1:0]  ov_q, ov_d;

  logic [3:0]  st_q, st_d;
  logic [10:0] cnt_q, cnt_d;   // scan position, one ahead of read data
  atbe_pkg::in_item_t it_q, it_d;
  atbe_pkg::out_item_t ob_q, ob_d, hold_q, hold_d;
  logic        ov_valid_q, ov_valid_d;
  logic        hit_q, hit_d, fr_q, fr_d, of_q, of_d, ofr_q, ofr_d, bfr_q, bfr_d;
  logic        any_q, any_d;
  logic [PW-1:0] pidx_q, pidx_d, pfree_q, pfree_d;
  logic [OW-1:0] oidx_q, oidx_d, ofree_q, ofree_d;
  logic [BW-1:0] bfree_q, bfree_d;
  logic [31:0] pdng_q, pdng_d, odng_q, odng_d, secs_q, secs_d;
  logic [15:0] ab_q, ab_d, phits_q, phits_d;
  logic [10:0] pks_q, pks_d;
  logic [TB-1:0] pfirst_q, pfirst_d;
  logic [15:0] esc_q, esc_d;

  logic [TB-1:0] now_t;
  assign now_t = it_q.now[TB-1:0];

  logic out_fire;
  assign out_fire = ov_valid_q && out_ready_i;
  assign out_valid_o = ov_valid_q;
  assign out_item_o  = ob_q;
  assign in_ready_o  = (st_q == S_IDLE) && !ov_valid_q;

  logic [PW-1:0] pc;
  logic [BW-1:0] bc;
  logic [OW-1:0] oc;
  assign pc = PW'(cnt_q - 11'd1);
  assign bc = BW'(cnt_q - 11'd1);
  assign oc = OW'(cnt_q - 11'd1);

  logic key_p, key_b, key_o;
  assign key_p = pr_hi == it_q.addr_hi && pr_lo == it_q.addr_lo && pr_ks[0] == it_q.addr_kind;
  assign key_b = br_hi == it_q.addr_hi && br_lo == it_q.addr_lo && br_ks[0] == it_q.addr_kind;
  assign key_o = or_hi == it_q.addr_hi && or_lo == it_q.addr_lo && or_kind == it_q.addr_kind;

  logic stale_hit, tick_rel;
  assign stale_hit = cnt_q != 0 && pv_q[pc] && 32'(TB'(now_t - pr_first)) > stale_q;
  assign tick_rel  = cnt_q != 0 && bv_q[bc] && br_dur != 0
                     && 32'(TB'(now_t - br_since)) > br_dur;

  logic [32:0] esc_nx;
  assign esc_nx = {1'b0, secs_q} + {2'b0, secs_q[31:1]};

  function automatic atbe_pkg::out_item_t simple(atbe_pkg::in_item_t it, logic [2:0] s);
    atbe_pkg::out_item_t r;
    r = '0;
    r.status = s;
    r.res_addr_hi = it.addr_hi;
    r.res_addr_lo = it.addr_lo;
    r.res_kind = it.addr_kind;
    r.res_service = it.service;
    r.last = 1'b1;
    return r;
  endfunction

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; it_d = it_q; ob_d = ob_q; hold_d = hold_q;
    ov_valid_d = ov_valid_q && !out_ready_i;
    pv_d = pv_q; bv_d = bv_q; ov_d = ov_q;
    hit_d = hit_q; fr_d = fr_q; of_d = of_q; ofr_d = ofr_q; bfr_d = bfr_q; any_d = any_q;
    pidx_d = pidx_q; pfree_d = pfree_q; oidx_d = oidx_q; ofree_d = ofree_q; bfree_d = bfree_q;
    pdng_d = pdng_q; odng_d = odng_q; secs_d = secs_q; ab_d = ab_q; phits_d = phits_q;
    pks_d = pks_q; pfirst_d = pfirst_q; esc_d = esc_q;
    p_we = 1'b0; b_we = 1'b0; o_we = 1'b0;
    p_wa = pidx_q; b_wa = bfree_q; o_wa = oidx_q;
    p_wd = '0; b_wd = '0; o_wd = '0;
    p_ra = PW'(cnt_q); b_ra = BW'(cnt_q); o_ra = OW'(cnt_q);
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          it_d = in_item_i;
          cnt_d = '0;
          hit_d = 1'b0; fr_d = 1'b0; of_d = 1'b0; ofr_d = 1'b0; bfr_d = 1'b0; any_d = 1'b0;
          st_d = (in_item_i.op == atbe_pkg::OpTick) ? S_TICK : S_PURGE;
        end
      end
      S_PURGE: begin
        if (stale_hit) pv_d[pc] = 1'b0;
        cnt_d = cnt_q + 11'd1;
        if (cnt_q == 11'(PEND_DEPTH)) begin cnt_d = '0; st_d = S_BSRCH; end
      end
      S_BSRCH: begin
        if (cnt_q != 0 && bv_q[bc] && key_b) hit_d = 1'b1;
        if (cnt_q != 0 && !bv_q[bc] && !bfr_q) begin bfr_d = 1'b1; bfree_d = bc; end
        cnt_d = cnt_q + 11'd1;
        if (cnt_q == 11'(BLK_DEPTH)) begin
          cnt_d = '0;
          if (hit_d) begin
            ob_d = simple(it_q, atbe_pkg::StAlready); st_d = S_OUT;
          end else if (it_q.whitelisted) begin
            ob_d = simple(it_q, atbe_pkg::StWhite); st_d = S_OUT;
          end else st_d = S_PSRCH;
        end
      end
      S_PSRCH: begin
        if (cnt_q != 0 && pv_q[pc] && key_p && !hit_q) begin hit_d = 1'b1; pidx_d = pc; end
        if (cnt_q != 0 && !pv_q[pc] && !fr_q) begin fr_d = 1'b1; pfree_d = pc; end
        cnt_d = cnt_q + 11'd1;
        if (cnt_q == 11'(PEND_DEPTH)) begin
          if (hit_d) begin
            p_ra = pidx_d; st_d = S_PREAD;
          end else if (fr_d) begin
            pidx_d = pfree_d;
            pv_d[pidx_d] = 1'b1;
            pks_d = {it_q.service, it_q.addr_kind};
            pfirst_d = now_t; phits_d = 16'd1;
            pdng_d = {22'd0, it_q.danger};
            st_d = S_PUPD;
          end else begin
            ob_d = simple(it_q, atbe_pkg::StFull); st_d = S_OUT;
          end
        end
      end
      S_PREAD: begin
        pks_d = pr_ks; pfirst_d = pr_first;
        phits_d = (pr_hits == 16'hFFFF) ? pr_hits : pr_hits + 16'd1;
        pdng_d = atbe_pkg::sat_add32(pr_dng, {22'd0, it_q.danger});
        st_d = S_PUPD;
      end
      S_PUPD: begin
        p_we = 1'b1;
        p_wd = {it_q.addr_hi, it_q.addr_lo, pks_q, pfirst_q, now_t, phits_q, pdng_q};
        cnt_d = '0; hit_d = 1'b0;
        if (pdng_q < abuse_thr_q) begin
          ob_d = simple(it_q, atbe_pkg::StCounted); st_d = S_OUT;
        end else st_d = S_OSRCH;
      end
      S_OSRCH: begin
        if (cnt_q != 0 && ov_q[oc] && key_o && !of_q) begin of_d = 1'b1; oidx_d = oc; end
        if (cnt_q != 0 && !ov_q[oc] && !ofr_q) begin ofr_d = 1'b1; ofree_d = oc; end
        cnt_d = cnt_q + 11'd1;
        if (cnt_q == 11'(OFF_DEPTH)) begin
          if ((!of_d && !ofr_d) || !bfr_q) begin
            ob_d = simple(it_q, atbe_pkg::StFull); st_d = S_OUT;
          end else begin
            o_ra = oidx_d; st_d = S_OUPD;
          end
        end
      end
      S_OUPD: begin
        if (of_q) begin
          ab_d = (or_ab == 16'hFFFF) ? or_ab : or_ab + 16'd1;
          odng_d = atbe_pkg::sat_add32(or_dng, pdng_q);
          o_wa = oidx_q;
        end else begin
          ab_d = 16'd1; odng_d = pdng_q; o_wa = ofree_q;
          ov_d[ofree_q] = 1'b1;
        end
        o_we = 1'b1;
        o_wd = {it_q.addr_hi, it_q.addr_lo, it_q.addr_kind, ab_d, odng_d, now_t};
        secs_d = pardon_q; esc_d = '0;
        st_d = S_ESC;
      end
      S_ESC: begin
        if (odng_q >= blk_thr_q) begin
          secs_d = '0; st_d = S_BWR;
        end else if (esc_q == ab_q || secs_q < 32'd2) st_d = S_BWR;
        else if (esc_nx[32]) begin secs_d = 32'hFFFF_FFFF; st_d = S_BWR; end
        else begin secs_d = esc_nx[31:0]; esc_d = esc_q + 16'd1; end
      end
      S_BWR: begin
        b_we = 1'b1;
        b_wd = {it_q.addr_hi, it_q.addr_lo, pks_q, now_t, secs_q};
        bv_d[bfree_q] = 1'b1;
        pv_d[pidx_q] = 1'b0;
        ob_d = simple(it_q, (odng_q >= blk_thr_q) ? atbe_pkg::StPerm : atbe_pkg::StBlocked);
        ob_d.block_seconds = secs_q;
        ob_d.offender_danger = odng_q;
        ob_d.offender_abuses = ab_q;
        ob_d.to_blacklist = (odng_q >= blk_thr_q) && bl_en_q;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_valid_q) begin ov_valid_d = 1'b1; st_d = S_IDLE; end
      end
      S_TICK: begin
        if (tick_rel && any_q && ov_valid_q && !out_ready_i) begin
          b_ra = bc;
        end else begin
          if (tick_rel) begin
            bv_d[bc] = 1'b0;
            hold_d = '0;
            hold_d.status = atbe_pkg::StReleased;
            hold_d.res_addr_hi = br_hi; hold_d.res_addr_lo = br_lo;
            hold_d.res_kind = br_ks[0]; hold_d.res_service = br_ks[10:1];
            hold_d.block_seconds = br_dur;
            any_d = 1'b1;
            if (any_q) begin ob_d = hold_q; ov_valid_d = 1'b1; end
          end
          cnt_d = cnt_q + 11'd1;
          if (cnt_q == 11'(BLK_DEPTH)) st_d = S_TOUT;
        end
      end
      S_TOUT: begin
        // flag the held release as last, or report that nothing expired
        if (!ov_valid_q || out_ready_i) begin
          if (any_q) ob_d = hold_q;
          else begin ob_d = '0; ob_d.status = atbe_pkg::StNone; end
          ob_d.last = 1'b1;
          ov_valid_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; ov_valid_q <= 1'b0;
      pv_q <= '0; bv_q <= '0; ov_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; ov_valid_q <= ov_valid_d;
      pv_q <= pv_d; bv_q <= bv_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; ob_q <= ob_d; hold_q <= hold_d;
    hit_q <= hit_d; fr_q <= fr_d; of_q <= of_d; ofr_q <= ofr_d; bfr_q <= bfr_d; any_q <= any_d;
    pidx_q <= pidx_d; pfree_q <= pfree_d; oidx_q <= oidx_d; ofree_q <= ofree_d;
    bfree_q <= bfree_d;
    pdng_q <= pdng_d; odng_q <= odng_d; secs_q <= secs_d; ab_q <= ab_d; phits_q <= phits_d;
    pks_q <= pks_d; pfirst_q <= pfirst_d; esc_q <= esc_d;
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken while result pending");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_item_o.last) |=> !out_valid_o)
    else $error("result after last");
  a_perm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == atbe_pkg::StPerm) |-> out_item_o.block_seconds == 0)
    else $error("permanent block with duration");

endmodule
